### rtl/core/mlpq_pkg.sv
`default_nettype none

package mlpq_pkg;

   // queue geometry
   localparam int NUM_LEVELS  = 32;
   localparam int LEVEL_DEPTH = 16;
   localparam int ID_BITS     = 8;

   localparam int LEVEL_BITS = $clog2(NUM_LEVELS);
   localparam int PTR_BITS   = $clog2(LEVEL_DEPTH);
   localparam int COUNT_BITS = $clog2(LEVEL_DEPTH + 1);
   localparam int SLICE_BITS = 6;
   localparam int ADDR_BITS  = LEVEL_BITS + PTR_BITS;
   localparam int RAM_DEPTH  = 2 ** ADDR_BITS;
   localparam int ENTRY_BITS = ID_BITS + SLICE_BITS;

   // field widths at the ports
   localparam int FIELD_ID_BITS    = 8;
   localparam int FIELD_LEVEL_BITS = 5;
   // wide enough to hold any level field and NUM_LEVELS itself
   localparam int LEVEL_CMP_BITS   = 8;
   localparam int ID_WIDE_BITS     = 16;

   typedef enum logic {
      REQ_ENQ = 1'b0,
      REQ_DEQ = 1'b1
   } req_code_type;

   typedef enum logic [1:0] {
      ST_ENQ   = 2'd0,
      ST_DEQ   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      req_code_type                req_type;
      logic [FIELD_ID_BITS-1:0]    thread_id;
      logic [FIELD_LEVEL_BITS-1:0] thread_level;
      logic [FIELD_LEVEL_BITS-1:0] running_level;
   } req_item_type;

   typedef struct packed {
      status_type                  status;
      logic [FIELD_ID_BITS-1:0]    out_thread_id;
      logic [FIELD_LEVEL_BITS-1:0] out_level;
      logic [SLICE_BITS-1:0]       out_timeslice;
   } rsp_item_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOK,
      S_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic load_out;
   } cmd_type;

endpackage

`default_nettype wire

### rtl/core/mlpq_ram.sv
`default_nettype none

module mlpq_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/core/mlpq_ctrl.sv
`default_nettype none

module mlpq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mlpq_pkg::cmd_type     cmd
);

   mlpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlpq_pkg::S_IDLE: begin
            if (req_valid) state_in = mlpq_pkg::S_LOOK;
         end
         mlpq_pkg::S_LOOK: begin
            state_in = mlpq_pkg::S_DONE;
         end
         mlpq_pkg::S_DONE: begin
            if (out_free) begin
               state_in = req_valid ? mlpq_pkg::S_LOOK : mlpq_pkg::S_IDLE;
            end
         end
         default: state_in = mlpq_pkg::S_IDLE;
      endcase
   end

   // outputs and commands
   always_comb begin
      req_stall    = 1'b1;
      cmd.exec     = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         mlpq_pkg::S_IDLE: begin
            req_stall = 1'b0;
         end
         mlpq_pkg::S_LOOK: begin
            cmd.exec = 1'b1;
         end
         mlpq_pkg::S_DONE: begin
            cmd.load_out = out_free;
            req_stall    = !out_free;
         end
         default: req_stall = 1'b1;
      endcase
      cmd.capture = req_valid && !req_stall;
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mlpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mlpq_dpath.sv
`default_nettype none

module mlpq_dpath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mlpq_pkg::cmd_type      cmd,
   input  wire mlpq_pkg::req_item_type req_data,
   output mlpq_pkg::rsp_item_type      rsp_data
);

   localparam int LB = mlpq_pkg::LEVEL_BITS;
   localparam int PB = mlpq_pkg::PTR_BITS;
   localparam int CB = mlpq_pkg::COUNT_BITS;
   localparam int SB = mlpq_pkg::SLICE_BITS;
   localparam int IB = mlpq_pkg::ID_BITS;
   localparam int NL = mlpq_pkg::NUM_LEVELS;

   mlpq_pkg::req_item_type req_ff;
   mlpq_pkg::status_type   status_ff, status_in;
   mlpq_pkg::rsp_item_type rsp_ff;
   logic [LB-1:0]          sel_ff;
   logic [CB-1:0]          count_ff [NL];
   logic [PB-1:0]          head_ff  [NL];
   logic [PB-1:0]          tail_ff  [NL];

   logic [mlpq_pkg::LEVEL_CMP_BITS-1:0] lvl_wide;
   logic                                lvl_ok;
   logic [LB-1:0]                       enq_idx, deq_idx, sel_idx;
   logic                                any_ready;
   logic [CB-1:0]                       sel_count;
   logic [PB-1:0]                       sel_head, sel_tail;
   logic [PB-1:0]                       head_next, tail_next;
   logic                                do_enq, do_deq;

   logic [mlpq_pkg::ID_WIDE_BITS-1:0]   id_wide;
   logic [IB-1:0]                       wr_id;
   logic [SB-1:0]                       wr_slice;
   logic [mlpq_pkg::ENTRY_BITS-1:0]     rd_entry;
   logic [mlpq_pkg::ID_WIDE_BITS-1:0]   rd_id_wide;
   logic [mlpq_pkg::LEVEL_CMP_BITS-1:0] sel_wide;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // enqueue level range check
   assign lvl_wide = mlpq_pkg::LEVEL_CMP_BITS'(req_ff.thread_level);
   assign lvl_ok   = lvl_wide < mlpq_pkg::LEVEL_CMP_BITS'(NL);
   assign enq_idx  = lvl_wide[LB-1:0];

   // most urgent nonempty level
   always_comb begin
      deq_idx   = '0;
      any_ready = 1'b0;
      for (int i = NL - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            deq_idx   = LB'(i);
            any_ready = 1'b1;
         end
      end
   end

   // selected level and its queue state
   assign sel_idx   = (req_ff.req_type == mlpq_pkg::REQ_DEQ) ? deq_idx : enq_idx;
   assign sel_count = count_ff[sel_idx];
   assign sel_head  = head_ff[sel_idx];
   assign sel_tail  = tail_ff[sel_idx];
   assign head_next = (sel_head == PB'(mlpq_pkg::LEVEL_DEPTH - 1)) ? '0 : sel_head + PB'(1);
   assign tail_next = (sel_tail == PB'(mlpq_pkg::LEVEL_DEPTH - 1)) ? '0 : sel_tail + PB'(1);

   // outcome of the request
   always_comb begin
      do_enq    = 1'b0;
      do_deq    = 1'b0;
      status_in = mlpq_pkg::ST_EMPTY;
      case (req_ff.req_type)
         mlpq_pkg::REQ_ENQ: begin
            if (!lvl_ok || sel_count >= CB'(mlpq_pkg::LEVEL_DEPTH)) begin
               status_in = mlpq_pkg::ST_FULL;
            end else begin
               status_in = mlpq_pkg::ST_ENQ;
               do_enq    = cmd.exec;
            end
         end
         default: begin
            if (any_ready) begin
               status_in = mlpq_pkg::ST_DEQ;
               do_deq    = cmd.exec;
            end
         end
      endcase
   end

   // per level count, head and tail
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
         end
      end else if (do_enq) begin
         count_ff[sel_idx] <= sel_count + CB'(1);
         tail_ff[sel_idx]  <= tail_next;
      end else if (do_deq) begin
         count_ff[sel_idx] <= sel_count - CB'(1);
         head_ff[sel_idx]  <= head_next;
      end
   end

   // level and status of the item in flight
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sel_ff    <= sel_idx;
         status_ff <= status_in;
      end
   end

   // entry written on enqueue
   assign id_wide  = mlpq_pkg::ID_WIDE_BITS'(req_ff.thread_id);
   assign wr_id    = id_wide[IB-1:0];
   assign wr_slice = SB'(req_ff.running_level) + SB'(1);

   mlpq_ram #(
      .WIDTH(mlpq_pkg::ENTRY_BITS),
      .DEPTH(mlpq_pkg::RAM_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (do_enq),
      .wr_addr ({sel_idx, sel_tail}),
      .wr_data ({wr_id, wr_slice}),
      .rd_en   (do_deq),
      .rd_addr ({sel_idx, sel_head}),
      .rd_data (rd_entry)
   );

   assign rd_id_wide = mlpq_pkg::ID_WIDE_BITS'(rd_entry[mlpq_pkg::ENTRY_BITS-1:SB]);
   assign sel_wide   = mlpq_pkg::LEVEL_CMP_BITS'(sel_ff);

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.status <= status_ff;
         if (status_ff == mlpq_pkg::ST_DEQ) begin
            rsp_ff.out_thread_id <= rd_id_wide[mlpq_pkg::FIELD_ID_BITS-1:0];
            rsp_ff.out_level     <= sel_wide[mlpq_pkg::FIELD_LEVEL_BITS-1:0];
            rsp_ff.out_timeslice <= rd_entry[SB-1:0];
         end else begin
            rsp_ff.out_thread_id <= '0;
            rsp_ff.out_level     <= '0;
            rsp_ff.out_timeslice <= '0;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

### rtl/core/multilevel_priority_ready_queue.sv
// each request passes through the look state, which updates the level's count, head and tail
//   and issues the registered read of the entry ram, then the done state, which loads the result
//   register; a new request is not taken before the previous one has reached the done state
// a request is taken while the previous result still waits in the output register
// reset clears all level counts, heads and tails; the entry ram is not cleared
`default_nettype none

module multilevel_priority_ready_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire mlpq_pkg::req_item_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output mlpq_pkg::rsp_item_type      rsp_data
);

   mlpq_pkg::cmd_type cmd;

   // sequencing and handshakes
   mlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // queue state, entry ram and result register
   mlpq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

### bench/multilevel_priority_ready_queue_test.sv
`default_nettype none

module multilevel_priority_ready_queue_test;
   import mlpq_pkg::*;

   localparam int HOLD_CYCLES     = 150;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SEGMENT_ITEMS   = 50;
   localparam int RANDOM_SEGMENTS = 17;
   localparam int HOLD_SEGMENT    = 3;
   localparam int DRAIN_SEGMENT   = 9;
   localparam int TAIL_CYCLES     = 8;
   localparam int MAX_REPORTS     = 10;

   // one row of the directed table; copies repeat the request with the id advancing by one
   typedef struct {
      req_item_type req;
      int unsigned  copies;
      bit           has_fixed;
      rsp_item_type fixed_rsp;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   // scheduler state as predicted: per-level fill, read and write slot, and the slot contents
   int unsigned          level_fill [NUM_LEVELS] = '{default: 0};
   int unsigned          level_rd   [NUM_LEVELS] = '{default: 0};
   int unsigned          level_wr   [NUM_LEVELS] = '{default: 0};
   logic [ID_BITS-1:0]    slot_thread [NUM_LEVELS*LEVEL_DEPTH];
   logic [SLICE_BITS-1:0] slot_slice  [NUM_LEVELS*LEVEL_DEPTH];

   rsp_item_type pending_rsp [$];
   int unsigned  error_count = 0;
   int unsigned  status_seen [4] = '{default: 0};
   int unsigned  input_stall_cycles = 0;
   int unsigned  hold_requests = 0;
   int unsigned  hold_served = 0;
   int unsigned  rsp_stall_left = 0;
   bit           rsp_calm = 1'b0;
   int unsigned  quiet_cycles = 0;

   multilevel_priority_ready_queue DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // next scheduler result for one request, updating the predicted queues
   function automatic rsp_item_type predict_schedule(input req_item_type r);
      rsp_item_type res;
      int unsigned  slot;
      int           lv;
      bit           found;
      res = '0;
      found = 1'b0;
      if (r.req_type == REQ_ENQ) begin
         if (r.thread_level >= NUM_LEVELS || level_fill[r.thread_level] >= LEVEL_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            slot = r.thread_level * LEVEL_DEPTH + level_wr[r.thread_level];
            slot_thread[slot] = r.thread_id[ID_BITS-1:0];
            slot_slice[slot] = SLICE_BITS'(r.running_level) + SLICE_BITS'(1);
            level_wr[r.thread_level] = (level_wr[r.thread_level] + 1) % LEVEL_DEPTH;
            level_fill[r.thread_level]++;
            res.status = ST_ENQ;
         end
      end else begin
         res.status = ST_EMPTY;
         // most urgent nonempty level gives up its head
         for (lv = 0; lv < NUM_LEVELS && !found; lv++) begin
            if (level_fill[lv] != 0) begin
               slot = lv * LEVEL_DEPTH + level_rd[lv];
               res.status = ST_DEQ;
               res.out_thread_id = FIELD_ID_BITS'(slot_thread[slot]);
               res.out_level = FIELD_LEVEL_BITS'(lv);
               res.out_timeslice = slot_slice[slot];
               level_rd[lv] = (level_rd[lv] + 1) % LEVEL_DEPTH;
               level_fill[lv]--;
               found = 1'b1;
            end
         end
      end
      return res;
   endfunction

   function automatic stim_row_type stim_row(input req_code_type kind, input logic [7:0] id,
                                             input logic [4:0] lvl, input logic [4:0] run,
                                             input int unsigned copies, input bit has_fixed,
                                             input status_type st, input logic [7:0] oid,
                                             input logic [4:0] olvl, input logic [5:0] oslice);
      stim_row_type row;
      row.req.req_type = kind;
      row.req.thread_id = id;
      row.req.thread_level = lvl;
      row.req.running_level = run;
      row.copies = copies;
      row.has_fixed = has_fixed;
      row.fixed_rsp.status = st;
      row.fixed_rsp.out_thread_id = oid;
      row.fixed_rsp.out_level = olvl;
      row.fixed_rsp.out_timeslice = oslice;
      return row;
   endfunction

   // gap length: mostly none or short, now and then long
   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic report_mismatch(input string what, input rsp_item_type want,
                                  input rsp_item_type got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected status %0d id %0d level %0d slice %0d,",
                  $time, what, want.status, want.out_thread_id, want.out_level,
                  want.out_timeslice);
         $display("   got status %0d id %0d level %0d slice %0d",
                  got.status, got.out_thread_id, got.out_level, got.out_timeslice);
      end
   endtask

   // offer one request and hold it until the transfer, then record its expected result
   task automatic offer_request(input req_item_type item, input bit has_fixed,
                                input rsp_item_type fixed_rsp);
      rsp_item_type predicted;
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = predict_schedule(item);
      if (has_fixed) predicted = fixed_rsp;
      status_seen[int'(predicted.status)]++;
      pending_rsp.push_back(predicted);
   endtask

   task automatic pause_sender(input int unsigned cycles);
      if (cycles != 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // result side: check each transfer, then pick the stall for the next cycle
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing outstanding", '0, rsp_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status
                || rsp_data.out_thread_id !== want.out_thread_id
                || rsp_data.out_level !== want.out_level
                || rsp_data.out_timeslice !== want.out_timeslice) begin
               report_mismatch("result mismatch", want, rsp_data);
            end
         end
      end
      if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         rsp_stall_left = HOLD_CYCLES;
      end
      if (rsp_stall_left != 0) begin
         rsp_stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_calm || reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall_left = idle_span();
         if (rsp_stall_left != 0) rsp_stall_left--;
         rsp_stall <= ($urandom_range(0, 99) < 30);
      end
   end

   // watchdog on cycles without any transfer, and a count of cycles the input is held off
   always @(posedge clock) begin
      if (req_valid && req_stall && !reset) input_stall_cycles++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                  $time, quiet_cycles, pending_rsp.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      stim_row_type directed_rows [$];
      req_item_type item;
      int unsigned  enq_pct;
      int unsigned  base_level;
      bit           narrow;
      bit           burst;
      directed_rows = '{
         // empty scheduler right after reset
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_EMPTY, 8'h00, 5'd0, 6'd0),
         // field extremes at the most and least urgent levels
         stim_row(REQ_ENQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_ENQ, 8'hFF, 5'd31, 5'd31, 1, 1, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_ENQ, 8'hA5, 5'd0, 5'd31, 1, 1, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_ENQ, 8'h5A, 5'd31, 5'd0, 1, 1, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_DEQ, 8'h00, 5'd0, 6'd1),
         stim_row(REQ_DEQ, 8'hFF, 5'd31, 5'd31, 1, 1, ST_DEQ, 8'hA5, 5'd0, 6'd32),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_DEQ, 8'hFF, 5'd31, 6'd32),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_DEQ, 8'h5A, 5'd31, 6'd1),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_EMPTY, 8'h00, 5'd0, 6'd0),
         // fill one level, then overflow it
         stim_row(REQ_ENQ, 8'h10, 5'd9, 5'd3, LEVEL_DEPTH, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_ENQ, 8'h77, 5'd9, 5'd4, 1, 1, ST_FULL, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_ENQ, 8'h30, 5'd20, 5'd10, 3, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         // a more urgent level goes first
         stim_row(REQ_ENQ, 8'h40, 5'd5, 5'd7, 1, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 2, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         // refill the full level so its write slot wraps
         stim_row(REQ_ENQ, 8'h78, 5'd9, 5'd12, 1, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 19, 0, ST_ENQ, 8'h00, 5'd0, 6'd0),
         stim_row(REQ_DEQ, 8'h00, 5'd0, 5'd0, 1, 1, ST_EMPTY, 8'h00, 5'd0, 6'd0)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         for (int unsigned c = 0; c < directed_rows[r].copies; c++) begin
            item = directed_rows[r].req;
            item.thread_id = directed_rows[r].req.thread_id + 8'(c);
            offer_request(item, directed_rows[r].has_fixed, directed_rows[r].fixed_rsp);
            pause_sender(idle_span());
         end
      end

      // random segments, each with its own enqueue mix and level spread
      for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
         case ($urandom_range(0, 2))
            0: begin
               enq_pct = 25;
            end
            1: begin
               enq_pct = 50;
            end
            default: begin
               enq_pct = 80;
            end
         endcase
         narrow = 1'($urandom_range(0, 1));
         base_level = $urandom_range(0, NUM_LEVELS - 3);
         burst = ($urandom_range(0, 3) == 0) || (seg == HOLD_SEGMENT);
         if (seg == HOLD_SEGMENT) hold_requests <= hold_requests + 1;
         if (seg == DRAIN_SEGMENT) drain_results();
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            item.req_type = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
            item.thread_id = FIELD_ID_BITS'($urandom_range(0, 255));
            item.thread_level = narrow ? FIELD_LEVEL_BITS'(base_level + $urandom_range(0, 2))
                                       : FIELD_LEVEL_BITS'($urandom_range(0, 31));
            item.running_level = FIELD_LEVEL_BITS'($urandom_range(0, 31));
            offer_request(item, 1'b0, '0);
            if (!burst) pause_sender(idle_span());
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d requests: %0d enqueued, %0d dequeued, %0d empty, %0d full drops",
               status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
               status_seen[int'(ST_ENQ)], status_seen[int'(ST_DEQ)],
               status_seen[int'(ST_EMPTY)], status_seen[int'(ST_FULL)]);
      $display("input held off for %0d cycles by back pressure, %0d mismatches",
               input_stall_cycles, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
